/* sv/sspc_pkg.sv */
// Shared types and constants for the servo status packet checker.
package sspc_pkg;

    localparam int MAX_LENGTH_DEF = 32;

    // Fixed byte positions inside a status packet.
    localparam int ID_BYTE_POS     = 2;
    localparam int LEN_BYTE_POS    = 3;
    localparam int ERR_BYTE_POS    = 4;
    localparam int PARAM_START_POS = 5;

    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_ID       = 3'd3,
        ST_DEVICE   = 3'd4
    } t_status;

    localparam logic KIND_PARAM  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Per-packet fields kept between beats.
    typedef struct packed {
        logic              active;
        logic [BYTE_W-1:0] packet_id;
        logic [BYTE_W-1:0] packet_length;
        logic [BYTE_W-1:0] error_byte;
        logic [BYTE_W-1:0] running_sum;
        logic [BYTE_W-1:0] target_id;
    } t_pkt_state;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] param_index;
        logic [BYTE_W-1:0] param_value;
        t_status           status;
        logic [BYTE_W-1:0] response_id;
        logic [BYTE_W-1:0] device_error;
    } t_result;

endpackage

/* sv/sspc_step.sv */
// Next-state and result logic for one received byte of a status packet.
module sspc_step #(
    parameter int MAX_LENGTH = sspc_pkg::MAX_LENGTH_DEF,
    parameter int POS_W      = $clog2(MAX_LENGTH + 4)
) (
    input  logic                       i_first,
    input  logic [sspc_pkg::BYTE_W-1:0] i_byte,
    input  logic [sspc_pkg::BYTE_W-1:0] i_exp_id,
    input  sspc_pkg::t_pkt_state       i_state,
    input  logic [POS_W-1:0]           i_pos,
    output sspc_pkg::t_pkt_state       o_state,
    output logic [POS_W-1:0]           o_pos,
    output logic                       o_res_valid,
    output sspc_pkg::t_result          o_res
);
    import sspc_pkg::*;

    t_pkt_state       base;
    logic [POS_W-1:0] pos;
    logic [BYTE_W-1:0] sum_add;
    logic [POS_W-1:0] param_end;
    logic [POS_W-1:0] param_off;

    always_comb begin
        base = i_state;
        pos  = i_pos;
        if (i_first) begin
            base        = '0;
            base.active = 1'b1;
            base.target_id = i_exp_id;
            pos         = '0;
        end
    end

    assign sum_add   = base.running_sum + i_byte;
    // Parameter bytes occupy positions below length + 3 when length > 2.
    assign param_end = POS_W'(base.packet_length) + POS_W'(PARAM_START_POS - 2);
    assign param_off = pos - POS_W'(PARAM_START_POS);

    always_comb begin
        o_state     = base;
        o_pos       = pos;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.status = ST_OK;
        if (base.active) begin
            o_pos = pos + 1'b1;
            if (pos < POS_W'(ID_BYTE_POS)) begin
                o_res_valid = 1'b0;
            end else if (pos == POS_W'(ID_BYTE_POS)) begin
                o_state.packet_id   = i_byte;
                o_state.running_sum = i_byte;
            end else if (pos == POS_W'(LEN_BYTE_POS)) begin
                o_state.packet_length = i_byte;
                o_state.running_sum   = sum_add;
                if (i_byte > BYTE_W'(MAX_LENGTH)) begin
                    o_state.active   = 1'b0;
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_STATUS;
                    o_res.status     = ST_TOO_LONG;
                    o_res.response_id  = base.packet_id;
                    o_res.device_error = base.error_byte;
                end
            end else if (pos == POS_W'(ERR_BYTE_POS)) begin
                o_state.error_byte  = i_byte;
                o_state.running_sum = sum_add;
            end else if (pos < param_end) begin
                o_state.running_sum = sum_add;
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_PARAM;
                o_res.param_index  = BYTE_W'(param_off);
                o_res.param_value  = i_byte;
                o_res.response_id  = base.packet_id;
                o_res.device_error = base.error_byte;
            end else begin
                o_state.active     = 1'b0;
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_STATUS;
                o_res.response_id  = base.packet_id;
                o_res.device_error = base.error_byte;
                if (~base.running_sum != i_byte) begin
                    o_res.status = ST_CHECKSUM;
                end else if (base.packet_id != base.target_id) begin
                    o_res.status = ST_ID;
                end else if (base.error_byte != '0) begin
                    o_res.status = ST_DEVICE;
                end else begin
                    o_res.status = ST_OK;
                end
            end
        end
    end

endmodule

/* sv/servo_status_packet_checker.sv */
// Top level of the servo status packet checker: beat registers and packet state.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: rx_byte[7:0], expected_id[15:8]; tuser: first_of_packet
//  m_axis    out        tuser: kind; tdata: param_index, param_value, status,
//                       response_id, device_error, zero fill
//
// One byte per cycle unless the output stalls: a beat is captured in an input
// register, evaluated in a single pass against the packet state and its result
// placed in an output register. Reset (synchronous, active low) empties both
// registers and makes the checker idle. A stalled output holds the result and
// the input register stops taking beats only while both registers are full.
module servo_status_packet_checker #(
    parameter int MAX_LENGTH = sspc_pkg::MAX_LENGTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] rx_byte, [15:8] expected_id
    input  logic [sspc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] first_of_packet
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] param_index, [15:8] param_value, [18:16] status,
    // [26:19] response_id, [34:27] device_error, [39:35] zero
    output logic [sspc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [0] kind
    output logic                           o_m_axis_tuser
);
    import sspc_pkg::*;

    localparam int POS_W = $clog2(MAX_LENGTH + 4);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [BYTE_W-1:0] r_in_exp;
    logic              r_in_first;

    t_pkt_state        r_state;
    t_pkt_state        n_state;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;

    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              n_out_valid;

    logic              consume;

    assign consume         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || consume;

    sspc_step #(
        .MAX_LENGTH (MAX_LENGTH),
        .POS_W      (POS_W)
    ) u_step (
        .i_first     (r_in_first),
        .i_byte      (r_in_byte),
        .i_exp_id    (r_in_exp),
        .i_state     (r_state),
        .i_pos       (r_pos),
        .o_state     (n_state),
        .o_pos       (n_pos),
        .o_res_valid (n_out_valid),
        .o_res       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_pos       <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (consume) begin
                r_state     <= n_state;
                r_pos       <= n_pos;
                r_out_valid <= n_out_valid;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata[BYTE_W-1:0];
            r_in_exp   <= i_s_axis_tdata[2*BYTE_W-1:BYTE_W];
            r_in_first <= i_s_axis_tuser;
        end
        if (consume && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {5'b0, r_out.device_error, r_out.response_id,
                              r_out.status, r_out.param_value, r_out.param_index};

endmodule
